/* rtl/work_stealing_deque_scheduler_defines.svh */
// Assertion macros shared by the checker of the work-stealing scheduler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WORK_STEALING_DEQUE_SCHEDULER_DEFINES_SVH
`define WORK_STEALING_DEQUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsds: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsds: next-cycle check failed");

`endif

/* rtl/wsds_pkg.sv */
// Shared constants, types and helpers of the work-stealing scheduler.
// No dependencies; imported by the interfaces and every module.
package wsds_pkg;

	localparam int NUM_PROCS   = 3;
	localparam int QUEUE_DEPTH = 16;

	localparam int KIND_W = 2;
	localparam int CPU_W  = 3;
	localparam int TASK_W = 16;
	localparam int STAT_W = 3;

	localparam int PROC_W    = $clog2(NUM_PROCS);
	localparam int IDX_W     = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int MEM_DEPTH = NUM_PROCS * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK      = 3'd0,
		STATUS_FULL    = 3'd1,
		STATUS_BADPROC = 3'd2,
		STATUS_RAN     = 3'd3,
		STATUS_IDLE    = 3'd4
	} status_t;

	// Classified command handed from the front end to the engine.
	typedef struct packed {
		logic              is_round;
		logic              at_front;
		logic [CPU_W-1:0]  cpu;
		logic [TASK_W-1:0] task_id;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [CPU_W-1:0]  proc;
		logic [TASK_W-1:0] task_out;
		logic              stolen;
		logic              all_empty;
		logic              last;
	} rsp_t;

	// Flat store address of ring position pos in queue p.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [PROC_W-1:0] p,
			input logic [IDX_W-1:0] pos);
		slot_addr = ADDR_W'(ADDR_W'(p) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(pos);
	endfunction

endpackage

/* rtl/wsds_req_if.sv */
// Request channel of the work-stealing scheduler: valid/ready plus item fields.
// Depends on wsds_pkg.
interface wsds_req_if import wsds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CPU_W-1:0]  cpu;
	logic [TASK_W-1:0] task_req;

	modport source (output valid, output kind, output cpu, output task_req, input ready);
	modport sink (input valid, input kind, input cpu, input task_req, output ready);
endinterface

/* rtl/wsds_rsp_if.sv */
// Result channel of the work-stealing scheduler: valid/ready plus result fields.
// Depends on wsds_pkg.
interface wsds_rsp_if import wsds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CPU_W-1:0]  proc;
	logic [TASK_W-1:0] task_out;
	logic              stolen;
	logic              all_empty;
	logic              last;

	modport source (output valid, output status, output proc, output task_out,
		output stolen, output all_empty, output last, input ready);
	modport sink (input valid, input status, input proc, input task_out,
		input stolen, input all_empty, input last, output ready);
endinterface

/* rtl/wsds_front.sv */
// Front end: accepts request transfers, classifies them and queues them.
// Depends on wsds_pkg and wsds_req_if.
module wsds_front import wsds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wsds_req_if.sink   req,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	cmd_t                  fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fill_q;
	logic                  push;
	logic                  pop;
	cmd_t                  in_cmd;

	assign req.ready = (fill_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	// Classify: the high kind bit selects a round, kind zero pushes at the front.
	always_comb begin
		in_cmd.is_round = req.kind[1];
		in_cmd.at_front = !req.kind[0];
		in_cmd.cpu      = req.cpu;
		in_cmd.task_id  = req.task_req;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/wsds_back.sv */
// Back end: owns the queue rings and task store, runs pushes and rounds,
// and holds the result output register. Depends on wsds_pkg and wsds_rsp_if.
module wsds_back import wsds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	wsds_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PUSH = 4'b0010,
		ST_PICK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [IDX_W-1:0]    head_q  [NUM_PROCS];
	logic [CNT_W-1:0]    count_q [NUM_PROCS];
	logic [PROC_W-1:0]   visit_q;
	logic [TASK_W-1:0]   store_q [MEM_DEPTH];
	logic [TASK_W-1:0]   rd_data_q;

	status_t             res_status_q;
	logic [CPU_W-1:0]    res_proc_q;
	logic                res_stolen_q;
	logic                res_last_q;
	logic                res_mem_q;

	logic                out_valid_q;
	rsp_t                out_q;

	logic [NUM_PROCS-1:0] busy;
	logic                 any_busy;
	logic [PROC_W-1:0]    first_busy;
	logic                 own_busy;
	logic [PROC_W-1:0]    victim;
	logic [SUM_W-1:0]     rear_sum;
	logic [IDX_W-1:0]     rear_pos;
	logic [IDX_W-1:0]     steal_next_head;
	logic [IDX_W-1:0]     pick_pos;

	logic [PROC_W-1:0]    cpu_idx;
	logic                 bad_cpu;
	logic                 full;
	logic                 push_ok;
	logic [IDX_W-1:0]     front_head;
	logic [SUM_W-1:0]     tail_sum;
	logic [IDX_W-1:0]     tail_pos;
	logic [IDX_W-1:0]     push_pos;

	logic                 mem_we;
	logic                 mem_re;
	logic                 out_free;
	logic                 visit_last;

	// Round victim search
	always_comb begin
		for (int p = 0; p < NUM_PROCS; p++) begin
			busy[p] = (count_q[p] != '0);
		end
		first_busy = '0;
		for (int p = NUM_PROCS - 1; p >= 0; p--) begin
			if (busy[p]) begin
				first_busy = PROC_W'(p);
			end
		end
	end

	assign any_busy   = |busy;
	assign own_busy   = busy[visit_q];
	assign victim     = own_busy ? visit_q : first_busy;
	assign visit_last = (visit_q == PROC_W'(NUM_PROCS - 1));

	assign rear_sum = SUM_W'(head_q[victim]) + SUM_W'(count_q[victim]) - SUM_W'(1);
	assign rear_pos = (rear_sum >= SUM_W'(QUEUE_DEPTH)) ?
		IDX_W'(rear_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(rear_sum);
	assign steal_next_head = (head_q[victim] == IDX_W'(QUEUE_DEPTH - 1)) ?
		'0 : head_q[victim] + 1'b1;
	assign pick_pos = own_busy ? rear_pos : head_q[victim];

	// Push decode
	assign cpu_idx = cmd_q.cpu[PROC_W-1:0];
	assign bad_cpu = ({1'b0, cmd_q.cpu} >= (CPU_W + 1)'(NUM_PROCS));
	assign full    = (count_q[cpu_idx] == CNT_W'(QUEUE_DEPTH));
	assign push_ok = !bad_cpu && !full;

	assign front_head = (head_q[cpu_idx] == '0) ?
		IDX_W'(QUEUE_DEPTH - 1) : head_q[cpu_idx] - 1'b1;
	assign tail_sum = SUM_W'(head_q[cpu_idx]) + SUM_W'(count_q[cpu_idx]);
	assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
	assign push_pos = cmd_q.at_front ? front_head : tail_pos;

	assign mem_we    = (state_q == ST_PUSH) && push_ok;
	assign mem_re    = (state_q == ST_PICK) && any_busy;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == ST_IDLE);

	// Task store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[slot_addr(cpu_idx, push_pos)] <= cmd_q.task_id;
		end
		if (mem_re) begin
			rd_data_q <= store_q[slot_addr(victim, pick_pos)];
		end
	end

	// Command and pending result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PUSH) begin
			if (bad_cpu) begin
				res_status_q <= STATUS_BADPROC;
			end else if (full) begin
				res_status_q <= STATUS_FULL;
			end else begin
				res_status_q <= STATUS_OK;
			end
			res_proc_q   <= cmd_q.cpu;
			res_stolen_q <= 1'b0;
			res_last_q   <= 1'b1;
			res_mem_q    <= 1'b0;
		end
		if (state_q == ST_PICK) begin
			res_status_q <= any_busy ? STATUS_RAN : STATUS_IDLE;
			res_proc_q   <= CPU_W'(visit_q);
			res_stolen_q <= any_busy && !own_busy;
			res_last_q   <= visit_last;
			res_mem_q    <= any_busy;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.status    <= res_status_q;
			out_q.proc      <= res_proc_q;
			out_q.task_out  <= res_mem_q ? rd_data_q : '0;
			out_q.stolen    <= res_stolen_q;
			out_q.all_empty <= res_last_q && !any_busy;
			out_q.last      <= res_last_q;
		end
	end

	// Sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			visit_q     <= '0;
			out_valid_q <= 1'b0;
			for (int p = 0; p < NUM_PROCS; p++) begin
				head_q[p]  <= '0;
				count_q[p] <= '0;
			end
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						visit_q <= '0;
						state_q <= cmd.is_round ? ST_PICK : ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						count_q[cpu_idx] <= count_q[cpu_idx] + 1'b1;
						if (cmd_q.at_front) begin
							head_q[cpu_idx] <= front_head;
						end
					end
					state_q <= ST_EMIT;
				end
				ST_PICK: begin
					if (any_busy) begin
						count_q[victim] <= count_q[victim] - 1'b1;
						if (!own_busy) begin
							head_q[victim] <= steal_next_head;
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (res_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							visit_q <= visit_q + 1'b1;
							state_q <= ST_PICK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.proc      = out_q.proc;
	assign rsp.task_out  = out_q.task_out;
	assign rsp.stolen    = out_q.stolen;
	assign rsp.all_empty = out_q.all_empty;
	assign rsp.last      = out_q.last;

endmodule

/* rtl/work_stealing_deque_scheduler.sv */
// Work-stealing deque scheduler, top level.
// Depends on wsds_pkg, wsds_req_if, wsds_rsp_if, wsds_front and wsds_back.
//
// Usage:
//   req carries one item per transfer: kind (push front, push rear, round),
//   cpu and task_req. rsp carries results: status, proc, task_out, stolen,
//   all_empty and last; last marks the final result of an item.
//   A push gives one result. A round gives one result per processor, in
//   ascending processor order; the final one carries all_empty.
// Sequencing:
//   A two-entry command queue absorbs requests while the engine works.
//   The engine takes one item at a time and accepts the next only once it
//   is back in idle. A push passes the idle, push and emit steps; a round
//   spends a pick step (victim search and store read) and an emit step per
//   processor, then returns to idle.
// Reset:
//   arst_n empties every queue and the command queue; the task store itself
//   is not cleared, no entry is read before it is written.
// Backpressure:
//   A stalled result holds in the output register; the engine waits in its
//   emit step, and the front end keeps taking requests until its queue fills.
module work_stealing_deque_scheduler import wsds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wsds_req_if.sink   req,
	wsds_rsp_if.source rsp
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Accept and classify requests; buffer them ahead of the engine.
	wsds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Run pushes and rounds against the queue rings; drive results.
	wsds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp)
	);

endmodule

/* rtl/wsds_checker.sv */
// Port-level checker for the work-stealing scheduler, bound to the top level.
// Depends on wsds_pkg and work_stealing_deque_scheduler_defines.svh.
`include "work_stealing_deque_scheduler_defines.svh"

module wsds_checker import wsds_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] rsp_status,
	input logic [CPU_W-1:0]  rsp_proc,
	input logic [TASK_W-1:0] rsp_task_out,
	input logic              rsp_stolen,
	input logic              rsp_all_empty,
	input logic              rsp_last
);

	// Hold a stalled result.
	`WSDS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_proc) && $stable(rsp_task_out) && $stable(rsp_last))

	// Push results are single, carry no task and are never stolen.
	`WSDS_ASSERT_IMPL(a_push_result, clk, arst_n, rsp_valid && (rsp_status == STATUS_OK || rsp_status == STATUS_FULL || rsp_status == STATUS_BADPROC), rsp_last && (rsp_task_out == '0) && !rsp_stolen)

	// Round results name a real processor.
	`WSDS_ASSERT_IMPL(a_round_proc, clk, arst_n, rsp_valid && (rsp_status == STATUS_RAN || rsp_status == STATUS_IDLE), rsp_proc <= CPU_W'(NUM_PROCS - 1))

	// Stolen only on a ran result; all_empty only on the final result.
	`WSDS_ASSERT_IMPL(a_flags, clk, arst_n, rsp_valid && (rsp_stolen || rsp_all_empty), (!rsp_stolen || rsp_status == STATUS_RAN) && (!rsp_all_empty || rsp_last))

endmodule

bind work_stealing_deque_scheduler wsds_checker u_wsds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_proc      (rsp.proc),
	.rsp_task_out  (rsp.task_out),
	.rsp_stolen    (rsp.stolen),
	.rsp_all_empty (rsp.all_empty),
	.rsp_last      (rsp.last)
);
